### rtl/vbp_pkg.sv
package vbp_pkg;

  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned OFFSET_W    = 13;
  localparam int unsigned BLOCK_W     = ADDR_W - OFFSET_W - 1;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 32;

  typedef enum logic [1:0] {
    REG_HIRES_MODE     = 2'd0,
    REG_SCREEN_BLOCK   = 2'd1,
    REG_INVERT_ENABLE  = 2'd2,
    REG_PALETTE_ENABLE = 2'd3
  } vbp_reg_t;

  typedef struct packed {
    logic               hires_mode;
    logic [BLOCK_W-1:0] screen_block;
    logic               invert_enable;
    logic               palette_enable;
  } vbp_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col_base;
    logic [7:0]         pixel_byte;
    logic               hires;
    logic               invert;
    logic               palette;
  } vbp_job_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } vbp_rgb_t;

  // palette: red from bit 1, blue from bit 3, green from bits 0 and 2
  // grey: index bits reversed, repeated in both nibbles
  function automatic vbp_rgb_t colour_rgb(input logic [3:0] idx, input logic palette);
    vbp_rgb_t   rgb;
    logic [7:0] grey;
    grey = {idx[0], idx[1], idx[2], idx[3], idx[0], idx[1], idx[2], idx[3]};
    if (palette) begin
      rgb.red   = {CHAN_W{idx[1]}};
      rgb.blue  = {CHAN_W{idx[3]}};
      rgb.green = {idx[0], idx[2], idx[0], idx[2], idx[0], idx[2], idx[0], idx[2]};
    end else begin
      rgb.red   = grey;
      rgb.green = grey;
      rgb.blue  = grey;
    end
    return rgb;
  endfunction

endpackage

### rtl/vbp_if.sv
interface vbp_in_if;
  import vbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic [7:0]        pixel_byte;

  modport source (output valid, output address, output pixel_byte, input ready);
  modport sink   (input valid, input address, input pixel_byte, output ready);
endinterface

interface vbp_out_if;
  import vbp_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;
  logic               last_pixel;

  modport source (output valid, output column, output row, output red, output green,
                  output blue, output last_pixel, input ready);
  modport sink   (input valid, input column, input row, input red, input green,
                  input blue, input last_pixel, output ready);
endinterface

### rtl/vbp_front.sv
module vbp_front (
  vbp_in_if.sink            pix_in,
  input  vbp_pkg::vbp_cfg_t cfg,
  input  logic              full,
  output logic              push,
  output vbp_pkg::vbp_job_t job
);
  import vbp_pkg::*;

  logic                in_window;
  logic [OFFSET_W-1:0] offset;

  assign offset    = pix_in.address[OFFSET_W-1:0];
  assign in_window = (pix_in.address[ADDR_W-1:OFFSET_W] == {1'b0, cfg.screen_block});

  assign pix_in.ready = !full;
  // words outside the screen window are taken and dropped
  assign push = pix_in.valid && !full && in_window;

  always_comb begin
    job.pixel_byte = pix_in.pixel_byte;
    job.hires      = cfg.hires_mode;
    job.invert     = cfg.invert_enable;
    job.palette    = cfg.palette_enable;
    if (cfg.hires_mode) begin
      job.row      = offset[12:5];
      job.col_base = {offset[4:0], 3'b000};
    end else begin
      job.row      = {1'b0, offset[12:6]};
      job.col_base = {1'b0, offset[5:0], 1'b0};
    end
  end

endmodule

### rtl/vbp_queue.sv
module vbp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vbp_pkg::vbp_job_t push_data,
  input  logic              pop,
  output vbp_pkg::vbp_job_t head,
  output logic              empty,
  output logic              full
);
  import vbp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  vbp_job_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/vbp_back.sv
module vbp_back (
  input  logic              clk,
  input  logic              rst,
  input  vbp_pkg::vbp_job_t head,
  input  logic              empty,
  output logic              pop,
  vbp_out_if.source         pix_out
);
  import vbp_pkg::*;

  logic [2:0]         idx;
  logic               advance;
  logic               last;
  logic [3:0]         nibble;
  logic               mono_bit;
  vbp_rgb_t           rgb;
  logic [COORD_W-1:0] col;

  logic               out_valid;
  logic [COORD_W-1:0] out_column;
  logic [COORD_W-1:0] out_row;
  vbp_rgb_t           out_rgb;
  logic               out_last;

  assign advance = !empty && (!out_valid || pix_out.ready);
  assign last    = head.hires ? (idx == 3'd7) : (idx == 3'd1);
  assign pop     = advance && last;

  always_comb begin
    nibble   = (idx[0] ? head.pixel_byte[3:0] : head.pixel_byte[7:4]) ^ {4{head.invert}};
    mono_bit = head.pixel_byte[~idx] ^ head.invert;
    col      = head.col_base + {5'b0, idx};
    if (head.hires) begin
      rgb.red   = {CHAN_W{mono_bit}};
      rgb.green = {CHAN_W{mono_bit}};
      rgb.blue  = {CHAN_W{mono_bit}};
    end else begin
      rgb = colour_rgb(nibble, head.palette);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= last ? 3'd0 : idx + 3'd1;
      end else if (pix_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_column <= col;
      out_row    <= head.row;
      out_rgb    <= rgb;
      out_last   <= last;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.column     = out_column;
  assign pix_out.row        = out_row;
  assign pix_out.red        = out_rgb.red;
  assign pix_out.green      = out_rgb.green;
  assign pix_out.blue       = out_rgb.blue;
  assign pix_out.last_pixel = out_last;

endmodule

### rtl/video_byte_to_pixels.sv
// Video byte to pixel converter.
// pix_in takes one video memory word (address, pixel_byte) per cycle when
// ready is high. A word inside the screen window (screen_block * 8 KiB,
// 8 KiB long) yields two colour pixels (128x128 grid) or eight mono pixels
// (256x256 grid, hires_mode); other words are taken and dropped.
// pix_out carries one pixel per cycle while pix_out.ready is high, with
// last_pixel on the final pixel of the word.
// A taken word is written into the queue; its first pixel is then registered
// in the output stage. The pixel serializer sends one pixel per cycle unless
// pix_out stalls; a hires word yields eight pixels, a colour word two. A queue
// of QUEUE_DEPTH words sits before the serializer; pix_in.ready drops while full.
// When pix_out.ready is low the output word holds and the serializer waits.
// Reset empties the queue and output stage and clears all four registers.
// Registers (APB, byte address 4*i): hires_mode, screen_block,
// invert_enable, palette_enable; write only while the block is idle.
module video_byte_to_pixels #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  vbp_in_if.sink                          pix_in,
  vbp_out_if.source                       pix_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vbp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [vbp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [vbp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import vbp_pkg::*;

  vbp_cfg_t cfg;
  vbp_reg_t reg_sel;
  logic     cfg_write;
  logic     push;
  logic     pop;
  logic     empty;
  logic     full;
  vbp_job_t job;
  vbp_job_t head;

  assign pready    = 1'b1;
  assign reg_sel   = vbp_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_HIRES_MODE:     cfg.hires_mode     <= pwdata[0];
        REG_SCREEN_BLOCK:   cfg.screen_block   <= pwdata[BLOCK_W-1:0];
        REG_INVERT_ENABLE:  cfg.invert_enable  <= pwdata[0];
        REG_PALETTE_ENABLE: cfg.palette_enable <= pwdata[0];
        default:            cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_HIRES_MODE:     prdata[0]           = cfg.hires_mode;
      REG_SCREEN_BLOCK:   prdata[BLOCK_W-1:0] = cfg.screen_block;
      REG_INVERT_ENABLE:  prdata[0]           = cfg.invert_enable;
      REG_PALETTE_ENABLE: prdata[0]           = cfg.palette_enable;
      default:            prdata              = '0;
    endcase
  end

  vbp_front u_front (
    .pix_in (pix_in),
    .cfg    (cfg),
    .full   (full),
    .push   (push),
    .job    (job)
  );

  vbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  vbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .pix_out (pix_out)
  );

endmodule
